/* hw/rtl/qsee_pkg.sv */
// Shared types, constants and helpers of the quoted string escape encoder.
package qsee_pkg;

   // Field widths
   localparam int unsigned CP_W     = 21;
   localparam int unsigned QUOTE_W  = 7;
   localparam int unsigned LIMIT_W  = 20;
   localparam int unsigned CSR_W    = 20;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned LEN_W    = 4;

   // Default depth of the descriptor queue between front and back
   localparam int unsigned QSEE_QUEUE_DEPTH = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_QUOTE_CHAR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHARP_HEX  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAR_LIMIT = 2'd2;

   // Register reset values
   localparam logic [QUOTE_W-1:0] QUOTE_RESET = 7'd34;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd1000000;

   // Character codes
   localparam logic [CP_W-1:0] CP_BACKSLASH = 21'h00005C;
   localparam logic [CP_W-1:0] CP_BEL       = 21'h000007;
   localparam logic [CP_W-1:0] CP_BS        = 21'h000008;
   localparam logic [CP_W-1:0] CP_TAB       = 21'h000009;
   localparam logic [CP_W-1:0] CP_LF        = 21'h00000A;
   localparam logic [CP_W-1:0] CP_VT        = 21'h00000B;
   localparam logic [CP_W-1:0] CP_FF        = 21'h00000C;
   localparam logic [CP_W-1:0] CP_CR        = 21'h00000D;
   localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
   localparam logic [CP_W-1:0] CP_REPLACE   = 21'h00FFFD;

   localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
   localparam logic [7:0] BYTE_X         = 8'h78;

   // How the character part of an item is written
   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_PAIR = 2'd1,
      KIND_HEX  = 2'd2,
      KIND_UTF8 = 2'd3
   } char_kind_type;

   // One classified item, as handed from front to back
   typedef struct packed {
      logic              open_quote;
      logic              close_quote;
      char_kind_type     kind;
      logic [7:0]        second;   // second byte of a two-byte escape
      logic [CP_W-1:0]   code;     // value for hex digits or UTF-8
      logic [LEN_W-1:0]  len;      // bytes of the character part
      logic [LEN_W-1:0]  count;    // bytes of the whole item
   } desc_type;

   // Lower-case hex digit of a nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         hex_char = 8'h30 + {4'h0, nib};
      end else begin
         hex_char = 8'h57 + {4'h0, nib};
      end
   endfunction

endpackage

/* hw/rtl/qsee_front.sv */
// Front part: accepts items, tracks per-string state and classifies each character.
module qsee_front import qsee_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [CP_W-1:0]      code_point,
   input  logic                 first_char,
   input  logic                 last_char,
   input  logic                 carries_char,
   input  logic [QUOTE_W-1:0]   quote_char,
   input  logic                 sharp_hex,
   input  logic [LIMIT_W-1:0]   char_limit,
   input  logic                 q_full,
   output logic                 q_push,
   output desc_type             q_data
);

   logic               last_hex_ff, last_hex_in;
   logic [LIMIT_W-1:0] taken_ff, taken_in;

   logic               accept;
   logic               prev_hex;
   logic [LIMIT_W-1:0] taken_eff;
   logic               take;
   logic [7:0]         letter;
   logic               is_digit;
   logic               is_ctrl;
   logic               use_hex;
   logic [2:0]         nib_n;
   logic [CP_W-1:0]    ucode;
   logic [LEN_W-1:0]   ulen;
   desc_type           d;

   assign accept = push && !q_full;

   // Start of a string clears the state before the character is handled
   assign prev_hex  = first_char ? 1'b0 : last_hex_ff;
   assign taken_eff = first_char ? '0 : taken_ff;
   assign take      = carries_char && (taken_eff < char_limit);

   // Letter escapes
   always_comb begin
      case (code_point)
         CP_BACKSLASH: letter = 8'h5C;
         CP_BEL:       letter = 8'h61;
         CP_BS:        letter = 8'h62;
         CP_FF:        letter = 8'h66;
         CP_LF:        letter = 8'h6E;
         CP_CR:        letter = 8'h72;
         CP_TAB:       letter = 8'h74;
         CP_VT:        letter = 8'h76;
         default:      letter = 8'h00;
      endcase
   end

   // Hex escape conditions
   assign is_digit = (code_point >= 21'h30 && code_point <= 21'h39) ||
                     (code_point >= 21'h61 && code_point <= 21'h66) ||
                     (code_point >= 21'h41 && code_point <= 21'h46);
   assign is_ctrl  = (code_point < 21'h20) ||
                     (code_point >= 21'h7F && code_point <= 21'hA0);
   assign use_hex  = (prev_hex && is_digit) || is_ctrl ||
                     (code_point >= 21'h100 && sharp_hex);

   // Number of hex digits, no leading zeros
   always_comb begin
      if (code_point[20]) begin
         nib_n = 3'd6;
      end else if (code_point[19:16] != 4'h0) begin
         nib_n = 3'd5;
      end else if (code_point[15:12] != 4'h0) begin
         nib_n = 3'd4;
      end else if (code_point[11:8] != 4'h0) begin
         nib_n = 3'd3;
      end else if (code_point[7:4] != 4'h0) begin
         nib_n = 3'd2;
      end else begin
         nib_n = 3'd1;
      end
   end

   // UTF-8 length, out-of-range values become the replacement character
   assign ucode = (code_point > CP_MAX) ? CP_REPLACE : code_point;
   always_comb begin
      if (ucode < 21'h80) begin
         ulen = 4'd1;
      end else if (ucode < 21'h800) begin
         ulen = 4'd2;
      end else if (ucode < 21'h10000) begin
         ulen = 4'd3;
      end else begin
         ulen = 4'd4;
      end
   end

   // Build the descriptor
   always_comb begin
      d.open_quote  = first_char;
      d.close_quote = last_char;
      d.kind        = KIND_NONE;
      d.second      = letter;
      d.code        = code_point;
      d.len         = '0;
      if (take) begin
         if (letter != 8'h00) begin
            d.kind = KIND_PAIR;
            d.len  = 4'd2;
         end else if (code_point == {{(CP_W-QUOTE_W){1'b0}}, quote_char}) begin
            d.kind   = KIND_PAIR;
            d.second = {1'b0, quote_char};
            d.len    = 4'd2;
         end else if (use_hex) begin
            d.kind = KIND_HEX;
            d.len  = 4'd2 + {1'b0, nib_n};
         end else begin
            d.kind = KIND_UTF8;
            d.code = ucode;
            d.len  = ulen;
         end
      end
      d.count = d.len + {3'b0, first_char} + {3'b0, last_char};
   end

   assign q_data = d;
   assign q_push = accept && (d.count != '0);

   // Advance the string state on each accepted item
   always_comb begin
      last_hex_in = last_hex_ff;
      taken_in    = taken_ff;
      if (accept) begin
         last_hex_in = take ? use_hex && (d.kind == KIND_HEX) : prev_hex;
         taken_in    = take ? taken_eff + 1'b1 : taken_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_hex_ff <= 1'b0;
         taken_ff    <= '0;
      end else begin
         last_hex_ff <= last_hex_in;
         taken_ff    <= taken_in;
      end
   end

endmodule

/* hw/rtl/qsee_queue.sv */
// Descriptor queue that decouples the front from the back.
module qsee_queue import qsee_pkg::*; #(
   parameter int unsigned DEPTH = QSEE_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  desc_type  push_data,
   output logic      full,
   input  logic      pop,
   output desc_type  head,
   output logic      empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   desc_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue popped while empty");
`endif

endmodule

/* hw/rtl/qsee_back.sv */
// Back part: expands each descriptor into output bytes, one per cycle unless the output stalls.
module qsee_back import qsee_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [QUOTE_W-1:0]   quote_char,
   input  desc_type             q_head,
   input  logic                 q_empty,
   output logic                 q_pop,
   output logic                 out_valid,
   input  logic                 out_pop,
   output logic [7:0]           out_byte,
   output logic                 out_last_of_run,
   output logic                 out_string_done
);

   desc_type           cur_ff, cur_in;
   logic               cur_valid_ff, cur_valid_in;
   logic [LEN_W-1:0]   idx_ff, idx_in;
   logic               ovalid_ff, ovalid_in;
   logic [7:0]         obyte_ff;
   logic               olast_ff;
   logic               odone_ff;

   logic               advance;
   logic               at_end;
   logic               load;
   logic [LEN_W-1:0]   j;
   logic [2:0]         dig;
   logic [1:0]         kpos;
   logic [3:0]         nib;
   logic [5:0]         six;
   logic [7:0]         char_byte;
   logic [7:0]         byte_now;
   logic [7:0]         quote_byte;

   assign quote_byte = {1'b0, quote_char};

   // Step when a descriptor is held and the output slot frees up
   assign advance = cur_valid_ff && (!ovalid_ff || out_pop);
   assign at_end  = (idx_ff == cur_ff.count - 1'b1);
   assign load    = !cur_valid_ff || (advance && at_end);
   assign q_pop   = load && !q_empty;

   // Position inside the character part
   assign j    = idx_ff - {3'b0, cur_ff.open_quote};
   assign dig  = 3'(cur_ff.len - 4'd1 - j);
   assign kpos = 2'(cur_ff.len - 4'd1 - j);

   always_comb begin
      case (dig)
         3'd0:    nib = cur_ff.code[3:0];
         3'd1:    nib = cur_ff.code[7:4];
         3'd2:    nib = cur_ff.code[11:8];
         3'd3:    nib = cur_ff.code[15:12];
         3'd4:    nib = cur_ff.code[19:16];
         3'd5:    nib = {3'b0, cur_ff.code[20]};
         default: nib = 4'h0;
      endcase
   end

   always_comb begin
      case (kpos)
         2'd0:    six = cur_ff.code[5:0];
         2'd1:    six = cur_ff.code[11:6];
         2'd2:    six = cur_ff.code[17:12];
         default: six = {3'b0, cur_ff.code[20:18]};
      endcase
   end

   // Byte of the character part
   always_comb begin
      char_byte = 8'h00;
      case (cur_ff.kind)
         KIND_PAIR: begin
            char_byte = (j == '0) ? BYTE_BACKSLASH : cur_ff.second;
         end
         KIND_HEX: begin
            if (j == 4'd0) begin
               char_byte = BYTE_BACKSLASH;
            end else if (j == 4'd1) begin
               char_byte = BYTE_X;
            end else begin
               char_byte = hex_char(nib);
            end
         end
         KIND_UTF8: begin
            if (j != '0) begin
               char_byte = {2'b10, six};
            end else begin
               case (cur_ff.len)
                  4'd1:    char_byte = {1'b0, cur_ff.code[6:0]};
                  4'd2:    char_byte = {3'b110, cur_ff.code[10:6]};
                  4'd3:    char_byte = {4'b1110, cur_ff.code[15:12]};
                  default: char_byte = {5'b11110, cur_ff.code[20:18]};
               endcase
            end
         end
         default: char_byte = 8'h00;
      endcase
   end

   // Pick opening quote, character byte or closing quote
   always_comb begin
      if (cur_ff.open_quote && idx_ff == '0) begin
         byte_now = quote_byte;
      end else if (j < cur_ff.len) begin
         byte_now = char_byte;
      end else begin
         byte_now = quote_byte;
      end
   end

   // Sequencer control
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         cur_valid_in = !q_empty;
         cur_in       = q_head;
         idx_in       = '0;
      end else if (advance) begin
         idx_in = idx_ff + 1'b1;
      end
      ovalid_in = advance ? 1'b1 : (out_pop ? 1'b0 : ovalid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         ovalid_ff    <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         ovalid_ff    <= ovalid_in;
      end
   end

   // Hold descriptor and output payload
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (advance) begin
         obyte_ff <= byte_now;
         olast_ff <= at_end;
         odone_ff <= at_end && cur_ff.close_quote;
      end
   end

   assign out_valid       = ovalid_ff;
   assign out_byte        = obyte_ff;
   assign out_last_of_run = olast_ff;
   assign out_string_done = odone_ff;

`ifndef SYNTH
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (idx_ff < cur_ff.count))
      else $error("byte index past end of item");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && odone_ff) |-> olast_ff)
      else $error("closing quote not on last byte of item");
`endif

endmodule

/* hw/rtl/quoted_string_escape_encoder.sv */
// Top level of the quoted string escape encoder: registers, front, queue and back.
// First byte of an item passes the queue, the held descriptor and the output register.
// Throughput: one result byte per cycle while results are popped; an item yields 1 to 10
// bytes (0 if nothing to write). Input takes an item every cycle while the descriptor queue
// has room; the byte sequencer in the back part sets the sustained rate of output bytes.
// Reset is synchronous: registers return to their defaults, state, queue and output clear.
module quoted_string_escape_encoder import qsee_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QSEE_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [CP_W-1:0]       req_code_point,
   input  logic                  req_first_char,
   input  logic                  req_last_char,
   input  logic                  req_carries_char,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last_of_run,
   output logic                  rsp_string_done,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wr_data
);

   logic [QUOTE_W-1:0] quote_ff, quote_in;
   logic               sharp_ff, sharp_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   logic       q_push;
   logic       q_full;
   logic       q_pop;
   logic       q_empty;
   desc_type   q_data;
   desc_type   q_head;
   logic       out_valid;

   // Decode register writes
   always_comb begin
      quote_in = quote_ff;
      sharp_in = sharp_ff;
      limit_in = limit_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_QUOTE_CHAR: quote_in = csr_wr_data[QUOTE_W-1:0];
            CSR_SHARP_HEX:  sharp_in = csr_wr_data[0];
            CSR_CHAR_LIMIT: limit_in = csr_wr_data[LIMIT_W-1:0];
            default:        quote_in = quote_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff <= QUOTE_RESET;
         sharp_ff <= 1'b0;
         limit_ff <= LIMIT_RESET;
      end else begin
         quote_ff <= quote_in;
         sharp_ff <= sharp_in;
         limit_ff <= limit_in;
      end
   end

   qsee_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (req_push),
      .code_point   (req_code_point),
      .first_char   (req_first_char),
      .last_char    (req_last_char),
      .carries_char (req_carries_char),
      .quote_char   (quote_ff),
      .sharp_hex    (sharp_ff),
      .char_limit   (limit_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_data)
   );

   qsee_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   qsee_back u_back (
      .clock           (clock),
      .reset           (reset),
      .quote_char      (quote_ff),
      .q_head          (q_head),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .out_valid       (out_valid),
      .out_pop         (rsp_pop),
      .out_byte        (rsp_out_byte),
      .out_last_of_run (rsp_last_of_run),
      .out_string_done (rsp_string_done)
   );

   assign req_full  = q_full;
   assign rsp_empty = !out_valid;

endmodule

/* sim/quoted_string_escape_encoder_tb.sv */
// Self-checking testbench of the quoted string escape encoder: directed table, then random strings.
module quoted_string_escape_encoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qsee_pkg::*;

   localparam int RUN_LIMIT    = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES  = 400;
   localparam int DIR_N        = 26;

   // One directed row; text holds the typed bytes right-aligned when typed is set
   typedef struct packed {
      logic [CP_W-1:0] code;
      logic            first;
      logic            last;
      logic            carries;
      logic            typed;
      logic [3:0]      n;
      logic [79:0]     text;
   } stim_row_type;

   // One expected output byte
   typedef struct packed {
      logic [7:0] data;
      logic       run_end;
      logic       closing;
   } enc_byte_type;

   // Directed items at reset settings: double quote, no sharp mode, limit 1000000
   localparam stim_row_type DIR_ROWS [DIR_N] = '{
      '{21'h000041, 1'b1, 1'b0, 1'b1, 1'b1, 4'd2, "\"A"},
      '{CP_BACKSLASH, 1'b0, 1'b0, 1'b1, 1'b1, 4'd2, "\\\\"},
      '{CP_BEL, 1'b0, 1'b0, 1'b1, 1'b1, 4'd2, "\\a"},
      '{CP_BS, 1'b0, 1'b0, 1'b1, 1'b1, 4'd2, "\\b"},
      '{CP_TAB, 1'b0, 1'b0, 1'b1, 1'b1, 4'd2, "\\t"},
      '{CP_LF, 1'b0, 1'b0, 1'b1, 1'b1, 4'd2, "\\n"},
      '{CP_VT, 1'b0, 1'b0, 1'b1, 1'b1, 4'd2, "\\v"},
      '{CP_FF, 1'b0, 1'b0, 1'b1, 1'b1, 4'd2, "\\f"},
      '{CP_CR, 1'b0, 1'b0, 1'b1, 1'b1, 4'd2, "\\r"},
      '{21'h000022, 1'b0, 1'b0, 1'b1, 1'b1, 4'd2, "\\\""},
      '{21'h000000, 1'b0, 1'b0, 1'b1, 1'b1, 4'd3, "\\x0"},
      '{21'h000061, 1'b0, 1'b0, 1'b1, 1'b1, 4'd4, "\\x61"},
      '{21'h000046, 1'b0, 1'b0, 1'b1, 1'b1, 4'd4, "\\x46"},
      '{21'h000047, 1'b0, 1'b0, 1'b1, 1'b1, 4'd1, "G"},
      '{21'h00007F, 1'b0, 1'b0, 1'b1, 1'b1, 4'd4, "\\x7f"},
      '{21'h0000A0, 1'b0, 1'b0, 1'b1, 1'b1, 4'd4, "\\xa0"},
      '{21'h0000A1, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0, 80'h0},
      '{21'h0007FF, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0, 80'h0},
      '{21'h00D800, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0, 80'h0},
      '{CP_MAX, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0, 80'h0},
      '{21'h1FFFFF, 1'b0, 1'b0, 1'b1, 1'b1, 4'd3, 80'hEFBFBD},
      '{21'h00007A, 1'b0, 1'b1, 1'b1, 1'b1, 4'd2, "z\""},
      '{21'h1FFFFF, 1'b1, 1'b1, 1'b0, 1'b1, 4'd2, "\"\""},
      '{21'h155555, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0, 80'h0},
      '{21'h0AAAAA, 1'b0, 1'b1, 1'b0, 1'b1, 4'd1, "\""},
      '{21'h00001F, 1'b1, 1'b1, 1'b1, 1'b1, 4'd6, "\"\\x1f\""}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [CP_W-1:0]      req_code_point = '0;
   logic                 req_first_char = 1'b0;
   logic                 req_last_char = 1'b0;
   logic                 req_carries_char = 1'b0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_last_of_run;
   logic                 rsp_string_done;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wr_data = '0;

   // Encoder copy: settings and string state
   logic [QUOTE_W-1:0]   cfg_quote = QUOTE_RESET;
   logic                 cfg_sharp = 1'b0;
   logic [LIMIT_W-1:0]   cfg_limit = LIMIT_RESET;
   logic                 prev_hex = 1'b0;
   logic [LIMIT_W-1:0]   taken = '0;

   logic [7:0]           enc_run [$];
   int                   enc_close;
   enc_byte_type         text_due [$];

   int                   send_idle_pct = 24;
   int                   recv_idle_pct = 50;
   int                   hold_asks = 0;
   int                   hold_done = 0;
   int                   hold_left = 0;
   int                   n_errors = 0;
   int unsigned          cycle_count = 0;

   quoted_string_escape_encoder dut (
      .clock, .reset,
      .req_push, .req_full, .req_code_point, .req_first_char, .req_last_char,
      .req_carries_char,
      .rsp_empty, .rsp_pop, .rsp_out_byte, .rsp_last_of_run, .rsp_string_done,
      .csr_wr_en, .csr_index, .csr_wr_data
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Work out the bytes of one item into enc_run and advance the string state
   task automatic encode_item(input logic [CP_W-1:0] cp, input logic f, input logic l,
                              input logic c);
      logic [7:0]      letter;
      logic            hex;
      logic [CP_W-1:0] u;
      int              nd;
      enc_run.delete();
      enc_close = -1;
      if (f) begin
         prev_hex = 1'b0;
         taken = '0;
         enc_run.push_back({1'b0, cfg_quote});
      end
      if (c && taken < cfg_limit) begin
         taken = taken + 1'b1;
         case (cp)
            CP_BACKSLASH: letter = "\\";
            CP_BEL:       letter = "a";
            CP_BS:        letter = "b";
            CP_FF:        letter = "f";
            CP_LF:        letter = "n";
            CP_CR:        letter = "r";
            CP_TAB:       letter = "t";
            CP_VT:        letter = "v";
            default:      letter = 8'h00;
         endcase
         hex = 1'b0;
         if (letter != 8'h00) begin
            enc_run.push_back(BYTE_BACKSLASH);
            enc_run.push_back(letter);
         end else if (cp == {14'd0, cfg_quote}) begin
            enc_run.push_back(BYTE_BACKSLASH);
            enc_run.push_back({1'b0, cfg_quote});
         end else begin
            hex = (prev_hex && ((cp >= "0" && cp <= "9") || (cp >= "a" && cp <= "f") ||
                                (cp >= "A" && cp <= "F")))
                  || cp < 21'h20 || (cp >= 21'h7F && cp <= 21'hA0)
                  || (cp >= 21'h100 && cfg_sharp);
            if (hex) begin
               // backslash, x, then digits without leading zeros
               nd = 1;
               while (nd < 6 && (cp >> (4 * nd)) != 0) nd++;
               enc_run.push_back(BYTE_BACKSLASH);
               enc_run.push_back(BYTE_X);
               for (int i = nd - 1; i >= 0; i--) begin
                  if (cp[4*i +: 4] < 4'd10) enc_run.push_back("0" + cp[4*i +: 4]);
                  else enc_run.push_back("a" + cp[4*i +: 4] - 8'd10);
               end
            end else begin
               // plain UTF-8, out-of-range values replaced
               u = (cp > CP_MAX) ? CP_REPLACE : cp;
               if (u < 21'h80) begin
                  enc_run.push_back(u[7:0]);
               end else if (u < 21'h800) begin
                  enc_run.push_back({3'b110, u[10:6]});
                  enc_run.push_back({2'b10, u[5:0]});
               end else if (u < 21'h10000) begin
                  enc_run.push_back({4'b1110, u[15:12]});
                  enc_run.push_back({2'b10, u[11:6]});
                  enc_run.push_back({2'b10, u[5:0]});
               end else begin
                  enc_run.push_back({5'b11110, u[20:18]});
                  enc_run.push_back({2'b10, u[17:12]});
                  enc_run.push_back({2'b10, u[11:6]});
                  enc_run.push_back({2'b10, u[5:0]});
               end
            end
         end
         prev_hex = hex;
      end
      if (l) begin
         enc_close = enc_run.size();
         enc_run.push_back({1'b0, cfg_quote});
      end
   endtask

   // Offer one item, hold it until taken, then queue its expected bytes
   task automatic send_item(input logic [CP_W-1:0] cp, input logic f, input logic l,
                            input logic c, input logic typed, input logic [3:0] n,
                            input logic [79:0] text);
      int nn;
      int sz;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push         <= 1'b1;
      req_code_point   <= cp;
      req_first_char   <= f;
      req_last_char    <= l;
      req_carries_char <= c;
      @(posedge clock);
      while (req_full) @(posedge clock);
      encode_item(cp, f, l, c);
      nn = n;
      sz = enc_run.size();
      if (typed) begin
         for (int k = 0; k < nn; k++)
            text_due.push_back('{text[8*(nn-1-k) +: 8], k == nn - 1, (k == nn - 1) && l});
      end else begin
         for (int k = 0; k < sz; k++)
            text_due.push_back('{enc_run[k], k == sz - 1, k == enc_close});
      end
   endtask

   // Drop push, wait for every expected byte, then let the pipeline empty
   task automatic wait_idle();
      req_push <= 1'b0;
      while (text_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers back to back
   task automatic set_config(input logic [QUOTE_W-1:0] q, input logic s,
                             input logic [LIMIT_W-1:0] lim);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_QUOTE_CHAR;
      csr_wr_data <= {{(CSR_W-QUOTE_W){1'b0}}, q};
      @(posedge clock);
      cfg_quote = q;
      csr_index   <= CSR_SHARP_HEX;
      csr_wr_data <= {{(CSR_W-1){1'b0}}, s};
      @(posedge clock);
      cfg_sharp = s;
      csr_index   <= CSR_CHAR_LIMIT;
      csr_wr_data <= lim;
      @(posedge clock);
      cfg_limit = lim;
      csr_wr_en <= 1'b0;
   endtask

   // Code point drawn from one of the interesting classes
   function automatic logic [CP_W-1:0] pick_code();
      int k;
      int v;
      case ($urandom_range(0, 9))
         0: v = $urandom_range(32'h20, 32'h7E);
         1: begin
            k = $urandom_range(0, 21);
            v = (k < 10) ? 32'h30 + k : (k < 16) ? 32'h61 + k - 10 : 32'h41 + k - 16;
         end
         2: v = $urandom_range(0, 32'h1F);
         3: v = $urandom_range(32'h7F, 32'hA0);
         4: v = $urandom_range(0, 1) ? {25'd0, cfg_quote} : 32'h5C;
         5: v = $urandom_range(0, 1) ? $urandom_range(32'hA1, 32'hFF)
                                     : $urandom_range(32'h100, 32'h7FF);
         6: v = ($urandom_range(0, 3) == 0) ? $urandom_range(32'hD800, 32'hDFFF)
                                            : $urandom_range(32'h800, 32'hFFFF);
         7: v = $urandom_range(32'h10000, 32'h10FFFF);
         8: v = $urandom_range(32'h110000, 32'h1FFFFF);
         default: v = $urandom & 32'h1FFFFF;
      endcase
      return v[CP_W-1:0];
   endfunction

   // Mostly well-formed strings, some broken ones and some loose noise items
   task automatic random_strings(input int n_items);
      int   sent;
      int   r;
      int   len;
      logic f;
      logic l;
      logic c;
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            f = $urandom_range(0, 1);
            l = $urandom_range(0, 1);
            c = $urandom_range(0, 1);
            if (f || l || c) sent++;
            send_item(pick_code(), f, l, c, 1'b0, 4'd0, 80'h0);
         end else if (r < 18) begin
            send_item(pick_code(), 1'b1, 1'b1, 1'b0, 1'b0, 4'd0, 80'h0);
            sent++;
         end else begin
            len = $urandom_range(1, 7);
            for (int i = 0; i < len; i++) begin
               // broken strings lose their opening or closing flag
               f = (i == 0) && !(r >= 18 && r < 23);
               l = (i == len - 1) && !(r >= 23 && r < 28);
               c = ($urandom_range(0, 15) != 0);
               if (f || l || c) sent++;
               send_item(pick_code(), f, l, c, 1'b0, 4'd0, 80'h0);
            end
         end
      end
   endtask

   task automatic run_phase(input logic [QUOTE_W-1:0] q, input logic s,
                            input logic [LIMIT_W-1:0] lim, input int send_pct,
                            input int recv_pct, input logic stall, input int n_items);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      set_config(q, s, lim);
      if (stall) hold_asks <= hold_asks + 1;
      random_strings(n_items);
      wait_idle();
   endtask

   // Check each popped byte against the oldest expectation, then drive pop
   always @(posedge clock) begin : rsp_check
      enc_byte_type exp_b;
      if (rsp_pop && !rsp_empty) begin
         if (text_due.size() == 0) begin
            $error("unexpected byte %h", rsp_out_byte);
            n_errors++;
         end else begin
            exp_b = text_due.pop_front();
            if (rsp_out_byte !== exp_b.data) begin
               $error("out_byte: expected %h, got %h", exp_b.data, rsp_out_byte);
               n_errors++;
            end
            if (rsp_last_of_run !== exp_b.run_end) begin
               $error("last_of_run: expected %b, got %b", exp_b.run_end, rsp_last_of_run);
               n_errors++;
            end
            if (rsp_string_done !== exp_b.closing) begin
               $error("string_done: expected %b, got %b", exp_b.closing, rsp_string_done);
               n_errors++;
            end
         end
      end
      // long hold-off on request, so the block fills and stalls its input
      if (hold_done != hold_asks) begin
         hold_left = HOLD_CYCLES;
         hold_done = hold_done + 1;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table at reset settings
      for (int i = 0; i < DIR_N; i++)
         send_item(DIR_ROWS[i].code, DIR_ROWS[i].first, DIR_ROWS[i].last,
                   DIR_ROWS[i].carries, DIR_ROWS[i].typed, DIR_ROWS[i].n, DIR_ROWS[i].text);
      wait_idle();

      // Random phases: sender lighter first, then receiver lighter, then no idling
      run_phase(7'd39,  1'b1, 20'd1000000, 24, 50, 1'b1, 74);
      run_phase(7'h5C,  1'b0, 20'd3,       24, 50, 1'b0, 74);
      run_phase(7'd0,   1'b1, 20'd0,       50, 24, 1'b0, 74);
      run_phase(7'd127, 1'b0, 20'd1,       50, 24, 1'b0, 74);
      run_phase(7'h0A,  1'b1, 20'd5,       0,  0,  1'b0, 74);
      run_phase(7'd34,  1'b0, 20'd1000000, 0,  0,  1'b0, 74);

      if (n_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
